/* sv/hash_set_linear_probe_core_macros.svh */
// assertion macros for the hash set core
`ifndef HASH_SET_LINEAR_PROBE_CORE_MACROS_SVH
`define HASH_SET_LINEAR_PROBE_CORE_MACROS_SVH

`define HSLP_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`define HSLP_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* sv/hslp_pkg.sv */
`default_nettype none
package hslp_pkg;
    localparam int SLOTS = 256;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [2:0] TAG_EMPTY = 3'd0;
    localparam logic [2:0] TAG_TOMB  = 3'd1;
    localparam logic [2:0] TAG_LIVE0 = 3'd2;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;

    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_PRESENT_ADD = 3'd1;
    localparam logic [2:0] ST_REMOVED     = 3'd2;
    localparam logic [2:0] ST_ABSENT      = 3'd3;
    localparam logic [2:0] ST_PRESENT     = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] NAN_HASH   = 32'h7FC00000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  key_kind;
        logic [63:0] key_value;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] entry_count;
        logic [7:0] slot_index;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_PROBE, S_DONE
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic hash_step;
        logic issue_read;
        logic probe_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic probe_end;
    } t_sts;
endpackage
`default_nettype wire

/* sv/hslp_ctrl.sv */
`default_nettype none
module hslp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  hslp_pkg::t_sts     i_sts,
    output hslp_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_idle
);
    import hslp_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_HASH;
            S_HASH:  if (i_sts.hash_last) n_state = S_READ;
            S_READ:  n_state = S_PROBE;
            S_PROBE: n_state = i_sts.probe_end ? S_DONE : S_READ;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_idle = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_busy = 1'b0;
                o_idle = 1'b1;
                o_cmd.load = i_start;
            end
            S_HASH:  o_cmd.hash_step = 1'b1;
            S_READ:  o_cmd.issue_read = 1'b1;
            S_PROBE: o_cmd.probe_step = 1'b1;
            S_DONE:  o_cmd.finish = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

/* sv/hslp_dp.sv */
`default_nettype none
module hslp_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  hslp_pkg::t_cmd     i_cmd,
    input  hslp_pkg::t_req     i_req,
    input  wire logic [8:0]    i_load_limit,
    output hslp_pkg::t_sts     o_sts,
    output logic               o_done,
    output hslp_pkg::t_rsp     o_rsp
);
    import hslp_pkg::*;

    logic [2:0]  r_tags [SLOTS];
    logic [63:0] r_keys [SLOTS];

    logic [1:0]  r_req, r_kind;
    logic [63:0] r_key;
    logic        r_nan;
    logic [31:0] r_hash;
    logic [2:0]  r_byte;
    logic [IDX_W-1:0] r_idx, r_start, r_tomb, r_end, r_clr;
    logic [CNT_W-1:0] r_n;
    logic        r_have_tomb, r_hit, r_avail;
    logic [2:0]  r_tag_rd;
    logic [63:0] r_key_rd;
    logic [CNT_W-1:0] r_live, r_used;
    logic        r_done;
    logic [2:0]  r_status;
    logic [7:0]  r_slot;

    // canonical key
    logic        c_short, c_nan;
    logic [63:0] c_key;
    always_comb begin
        c_short = (i_req.key_kind == 2'd0) || (i_req.key_kind == 2'd2);
        c_key   = c_short ? {32'd0, i_req.key_value[31:0]} : i_req.key_value;
        c_nan   = 1'b0;
        if (i_req.key_kind == 2'd2) begin
            c_nan = (c_key[30:23] == 8'hFF) && (c_key[22:0] != 23'd0);
            if (c_nan) c_key = 64'h7FC00000;
            else if (c_key == 64'h80000000) c_key = '0;
        end else if (i_req.key_kind == 2'd3) begin
            c_nan = (c_key[62:52] == 11'h7FF) && (c_key[51:0] != 52'd0);
            if (c_nan) c_key = 64'h7FF8000000000000;
            else if (c_key == 64'h8000000000000000) c_key = '0;
        end
    end

    logic [7:0]  h_b;
    logic [31:0] h_mul;
    logic        h_short;
    always_comb begin
        h_b     = r_key[{r_byte, 3'b000} +: 8];
        h_mul   = (r_hash ^ {24'd0, h_b}) * FNV_PRIME;
        h_short = (r_kind == 2'd0) || (r_kind == 2'd2);
    end

    logic hash_last;
    assign hash_last = r_nan || (r_byte == (h_short ? 3'd3 : 3'd7));

    logic p_empty, p_tomb, p_match, p_last;
    always_comb begin
        p_empty = (r_tag_rd == TAG_EMPTY);
        p_tomb  = (r_tag_rd == TAG_TOMB);
        p_match = (r_tag_rd == (TAG_LIVE0 + {1'b0, r_kind})) && (r_key_rd == r_key);
        p_last  = (r_n == CNT_W'(SLOTS - 1));
    end

    assign o_sts.clear_last = (r_clr == IDX_W'(SLOTS - 1));
    assign o_sts.hash_last  = hash_last;
    assign o_sts.probe_end  = p_empty || p_match || p_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) r_tags[r_clr] <= TAG_EMPTY;
        if (i_cmd.issue_read) begin
            r_tag_rd <= r_tags[r_idx];
            r_key_rd <= r_keys[r_idx];
        end
        if (i_cmd.finish && r_req == REQ_ADD && !r_hit && r_avail
            && ({1'b0, r_used} < {1'b0, i_load_limit})) begin
            r_tags[r_end] <= TAG_LIVE0 + {1'b0, r_kind};
            r_keys[r_end] <= r_key;
        end
        if (i_cmd.finish && r_req == REQ_REMOVE && r_hit)
            r_tags[r_end] <= TAG_TOMB;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req.req_type;
            r_kind <= i_req.key_kind;
            r_key  <= c_key;
            r_nan  <= c_nan;
            r_hash <= FNV_OFFSET;
            r_byte <= '0;
        end
        if (i_cmd.hash_step) begin
            if (r_nan) r_hash <= NAN_HASH;
            else       r_hash <= h_mul;
            r_byte <= r_byte + 3'd1;
            if (hash_last) begin
                r_idx   <= r_nan ? NAN_HASH[IDX_W-1:0] : h_mul[IDX_W-1:0];
                r_start <= r_nan ? NAN_HASH[IDX_W-1:0] : h_mul[IDX_W-1:0];
                r_n     <= '0;
                r_have_tomb <= 1'b0;
            end
        end
        if (i_cmd.probe_step) begin
            // empty and match never hold together
            r_hit   <= p_match;
            r_avail <= p_empty || (p_last && !p_match && (r_have_tomb || p_tomb));
            if (p_empty) begin
                r_end   <= r_have_tomb ? r_tomb : r_idx;
            end else if (p_match) begin
                r_end <= r_idx;
            end else if (p_last) begin
                r_end   <= r_have_tomb ? r_tomb : (p_tomb ? r_idx : r_start);
            end
            if (p_tomb && !r_have_tomb) begin
                r_have_tomb <= 1'b1;
                r_tomb      <= r_idx;
            end
            r_idx <= r_idx + 1'b1;
            r_n   <= r_n + 1'b1;
        end
        if (i_cmd.finish) begin
            r_slot <= 8'(r_end);
            if (r_req == REQ_ADD) begin
                if (r_hit) r_status <= ST_PRESENT_ADD;
                else if (!r_avail || !({1'b0, r_used} < {1'b0, i_load_limit}))
                    r_status <= ST_FULL;
                else r_status <= ST_INSERTED;
            end else if (r_req == REQ_REMOVE) begin
                r_status <= r_hit ? ST_REMOVED : ST_ABSENT;
            end else begin
                r_status <= r_hit ? ST_PRESENT : ST_ABSENT;
            end
        end
    end

    logic do_ins, do_rem;
    assign do_ins = i_cmd.finish && r_req == REQ_ADD && !r_hit && r_avail
                    && ({1'b0, r_used} < {1'b0, i_load_limit});
    assign do_rem = i_cmd.finish && r_req == REQ_REMOVE && r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_live <= '0;
            r_used <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.clear_step) r_clr <= r_clr + 1'b1;
            if (do_ins) begin
                r_live <= r_live + 1'b1;
                if (r_tag_rd == TAG_EMPTY && r_end == r_idx - 1'b1 && !r_have_tomb)
                    r_used <= r_used + 1'b1;
            end
            if (do_rem && r_live != '0) r_live <= r_live - 1'b1;
        end
    end

    logic [CNT_W-1:0] live_after;
    assign live_after = r_live;
    assign o_done = r_done;
    always_comb begin
        o_rsp.status      = r_status;
        o_rsp.slot_index  = r_slot;
        o_rsp.entry_count = 9'(live_after);
    end
endmodule
`default_nettype wire

/* sv/hash_set_linear_probe_core.sv */
// hash set core, open addressing with linear probing, fnv-1a key hash
// sequence: load, byte-serial hash (4 or 8 key bytes, a nan key takes the fixed nan hash), then
// a slot read and a probe step per probed slot, a finish step and a registered result strobe
// one request at a time: busy stays high from the hash through the finish step
// reset: synchronous active low, then a tag clearing pass over every slot with busy high
// results are strobed for one cycle; the receiver cannot stall
`default_nettype none
`include "hash_set_linear_probe_core_macros.svh"
module hash_set_linear_probe_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  hslp_pkg::t_req     i_req,
    output logic               o_valid,
    output hslp_pkg::t_rsp     o_rsp,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [8:0]    i_cfg_data
);
    import hslp_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;
    logic [8:0] r_load_limit;

    // load limit register, taken only while no request is in flight
    assign o_cfg_ready = idle && !start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_load_limit <= 9'd192;
        else if (i_cfg_valid && o_cfg_ready) r_load_limit <= i_cfg_data;
    end

    // sequencer
    hslp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_idle  (idle)
    );

    // hash, probe and slot stores
    hslp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (i_req),
        .i_load_limit (r_load_limit),
        .o_sts        (sts),
        .o_done       (o_valid),
        .o_rsp        (o_rsp)
    );

    `HSLP_ASSERT_IMPL(a_idle_not_busy, i_clk, i_rst_n, idle, !busy, "idle while busy")
    `HSLP_ASSERT_NEXT(a_finish_strobe, i_clk, i_rst_n, cmd.finish, o_valid, "no result strobe")
    `HSLP_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(cmd), "commands overlap")
endmodule
`default_nettype wire

/* dv/tb_hash_set_linear_probe_core.sv */
`default_nettype none
module tb_hash_set_linear_probe_core;
    timeunit 1ns;
    timeprecision 1ps;
    import hslp_pkg::*;

    // request and key kind codes absent from the package
    localparam logic [1:0] REQ_TEST   = 2'd2;
    localparam logic [1:0] REQ_SPARE  = 2'd3;
    localparam logic [1:0] KIND_I32   = 2'd0;
    localparam logic [1:0] KIND_I64   = 2'd1;
    localparam logic [1:0] KIND_F32   = 2'd2;
    localparam logic [1:0] KIND_F64   = 2'd3;
    localparam int         DRAIN_WAIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;

    hash_set_linear_probe_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_rsp(o_rsp), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the table
    logic [2:0]  shadow_tag [SLOTS];
    logic [63:0] shadow_key [SLOTS];
    int unsigned shadow_live;
    int unsigned shadow_used;
    logic [8:0]  shadow_limit;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   error_count = 0;
    bit   gaps_on = 1'b1;
    bit   hold_sender = 1'b0;
    bit   cfg_pending = 1'b0;
    logic [8:0] cfg_word;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic bit is_nan(logic [1:0] kind, logic [63:0] v);
        if (kind == KIND_F32)
            return v[30:23] == 8'hFF && v[22:0] != 0;
        if (kind == KIND_F64)
            return v[62:52] == 11'h7FF && v[51:0] != 0;
        return 1'b0;
    endfunction

    function automatic logic [63:0] canonical(logic [1:0] kind, logic [63:0] v);
        if (kind == KIND_I32 || kind == KIND_F32)
            v = {32'h0, v[31:0]};
        if (kind == KIND_F32) begin
            if (is_nan(kind, v)) return 64'h7FC00000;
            if (v == 64'h80000000) return 64'h0;
        end else if (kind == KIND_F64) begin
            if (is_nan(kind, v)) return 64'h7FF8000000000000;
            if (v == 64'h8000000000000000) return 64'h0;
        end
        return v;
    endfunction

    function automatic logic [31:0] fnv_hash(logic [1:0] kind, logic [63:0] c);
        logic [31:0] h;
        int n;
        h = 32'd2166136261;
        n = (kind == KIND_I32 || kind == KIND_F32) ? 4 : 8;
        if (is_nan(kind, c)) return 32'h7FC00000;
        for (int i = 0; i < n; i++)
            h = (h ^ {24'h0, c[8*i +: 8]}) * 32'd16777619;
        return h;
    endfunction

    // apply one request to the shadow table and return its response
    function automatic t_rsp table_lookup(t_req r);
        logic [63:0] c;
        int unsigned start_idx, idx, tomb;
        bit have_tomb, hit, avail, done;
        logic [2:0] st;
        t_rsp rsp;
        c = canonical(r.key_kind, r.key_value);
        start_idx = fnv_hash(r.key_kind, c) % SLOTS;
        idx = start_idx;
        have_tomb = 0; hit = 0; avail = 0; done = 0; tomb = 0;
        for (int n = 0; n < SLOTS && !done; n++) begin
            if (shadow_tag[idx] == TAG_EMPTY) begin
                avail = 1; done = 1;
                if (have_tomb) idx = tomb;
            end else if (shadow_tag[idx] == TAG_TOMB) begin
                if (!have_tomb) begin
                    have_tomb = 1; tomb = idx;
                end
            end else if (shadow_tag[idx] == TAG_LIVE0 + r.key_kind && shadow_key[idx] == c) begin
                hit = 1; done = 1;
            end
            if (!done) idx = (idx + 1) % SLOTS;
        end
        if (!done) begin
            if (have_tomb) begin
                avail = 1; idx = tomb;
            end else begin
                idx = start_idx;
            end
        end
        if (r.req_type == REQ_ADD) begin
            if (hit) st = ST_PRESENT_ADD;
            else if (!avail || shadow_used >= shadow_limit) st = ST_FULL;
            else begin
                if (shadow_tag[idx] == TAG_EMPTY) shadow_used++;
                shadow_tag[idx] = TAG_LIVE0 + r.key_kind;
                shadow_key[idx] = c;
                shadow_live++;
                st = ST_INSERTED;
            end
        end else if (r.req_type == REQ_REMOVE) begin
            if (hit) begin
                shadow_tag[idx] = TAG_TOMB;
                if (shadow_live > 0) shadow_live--;
                st = ST_REMOVED;
            end else st = ST_ABSENT;
        end else begin
            st = hit ? ST_PRESENT : ST_ABSENT;
        end
        rsp.status = st;
        rsp.entry_count = shadow_live[8:0];
        rsp.slot_index = idx[7:0];
        return rsp;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (start && !busy) begin
            expected_rsps.push_back(table_lookup(i_req));
            void'(pending_reqs.pop_front());
        end
        if (i_rst_n && pending_reqs.size() > 0 && !hold_sender &&
            !(gaps_on && $urandom_range(99) < 17)) begin
            start <= 1'b1;
            i_req <= (start && !busy && pending_reqs.size() > 0) ? pending_reqs[0] :
                     (start ? i_req : pending_reqs[0]);
        end else begin
            start <= 1'b0;
        end
    end

    // config write channel
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            shadow_limit = i_cfg_data;
            i_cfg_valid <= 1'b0;
            cfg_pending <= 1'b0;
        end else if (cfg_pending) begin
            i_cfg_valid <= 1'b1;
            i_cfg_data <= cfg_word;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response, status", o_rsp.status, -1);
            end else begin
                t_rsp want;
                want = expected_rsps.pop_front();
                if (o_rsp.status != want.status)
                    report_mismatch("status", o_rsp.status, want.status);
                if (o_rsp.entry_count != want.entry_count)
                    report_mismatch("entry_count", o_rsp.entry_count, want.entry_count);
                if (o_rsp.slot_index != want.slot_index)
                    report_mismatch("slot_index", o_rsp.slot_index, want.slot_index);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // key drawn from a small pool so adds, removes and tests collide often
    function automatic t_req pick_req(int pool);
        t_req r;
        int sel;
        r.key_kind = 2'($urandom_range(3));
        sel = $urandom_range(pool - 1);
        r.key_value = {32'h0, sel * 32'h9E3779B1};
        if ($urandom_range(9) == 0) r.key_value = rand64();
        else if ($urandom_range(9) == 0) r.key_value[63:32] = sel;
        case ($urandom_range(19))
            0: r.key_value = 64'h8000000000000000;
            1: r.key_value = 64'h80000000;
            2: r.key_value = {32'h0, 9'h0FF, 23'($urandom)} | 64'h7F800001;
            3: r.key_value = {12'h7FF, 52'(rand64())} | 64'h1;
            default: ;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: r.req_type = REQ_ADD;
            4, 5, 6: r.req_type = REQ_REMOVE;
            7, 8: r.req_type = REQ_TEST;
            default: r.req_type = REQ_SPARE;
        endcase
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [8:0] v);
        cfg_word = v;
        cfg_pending = 1'b1;
        while (cfg_pending) @(posedge i_clk);
    endtask

    task automatic push(logic [1:0] rt, logic [1:0] kind, logic [63:0] v);
        t_req r;
        r.req_type = rt; r.key_kind = kind; r.key_value = v;
        pending_reqs.push_back(r);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_tag[i] = TAG_EMPTY;
            shadow_key[i] = '0;
        end
        shadow_live = 0; shadow_used = 0; shadow_limit = 9'd192;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, signed zeros, nans, kind mismatch, spare request type
        push(REQ_ADD, KIND_I32, 64'h0);
        push(REQ_ADD, KIND_I32, 64'hFFFFFFFF_FFFFFFFF);
        push(REQ_ADD, KIND_I64, 64'hFFFFFFFF_FFFFFFFF);
        push(REQ_TEST, KIND_I64, 64'h0);
        push(REQ_ADD, KIND_F32, 64'h80000000);
        push(REQ_ADD, KIND_F32, 64'h0);
        push(REQ_ADD, KIND_F32, 64'h7FC00001);
        push(REQ_TEST, KIND_F32, 64'hFFFFFFFF);
        push(REQ_ADD, KIND_F64, 64'h8000000000000000);
        push(REQ_TEST, KIND_F64, 64'h0);
        push(REQ_ADD, KIND_F64, 64'hFFF0000000000001);
        push(REQ_SPARE, KIND_F64, 64'h7FF8000000000000);
        push(REQ_REMOVE, KIND_I32, 64'h0);
        push(REQ_REMOVE, KIND_I32, 64'h0);
        push(REQ_ADD, KIND_I32, 64'h0);
        push(REQ_REMOVE, KIND_F32, 64'hFF800001);
        push(REQ_TEST, KIND_F32, 64'h7FC00000);
        push(REQ_TEST, KIND_I32, 64'hAAAAAAAA_55555555);
        wait_drained();
        // tiny limits, the full status and a zero limit
        set_limit(9'd0);
        push(REQ_ADD, KIND_I64, 64'h1234);
        wait_drained();
        set_limit(9'd14);
        for (int i = 0; i < 12; i++) push(REQ_ADD, KIND_I64, 64'(i + 100));
        wait_drained();
        // random phases over several limits; a limit of 256 admits every slot
        for (int k = 0; k < 6; k++) begin
            logic [8:0] lims [6];
            int pool;
            lims = '{9'd40, 9'd256, 9'd1, 9'd120, 9'd511, 9'd192};
            set_limit(lims[k]);
            pool = (k == 1) ? 400 : 60;
            gaps_on = (k != 3);
            for (int i = 0; i < 220; i++) pending_reqs.push_back(pick_req(pool));
            if (k == 4) begin
                // sender holds off until every response is back
                while (pending_reqs.size() > 110) @(posedge i_clk);
                hold_sender = 1'b1;
                @(posedge i_clk);
                while (start || expected_rsps.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
